// File: rtl/ntbp_pkg.sv
// ----------------------------------------------------------------------------
// ntbp_pkg
// Types, constants and byte decode shared by the nucleotide packer.
// ----------------------------------------------------------------------------
package ntbp_pkg;

  localparam int unsigned BasesPerWordDefault = 32;
  localparam int unsigned WordW  = 64;
  localparam int unsigned LenW   = 26;
  localparam int unsigned ValidW = 6;
  localparam int unsigned ByteW  = 8;

  localparam logic [LenW-1:0] HardLengthLimit = 26'd67108861;

  typedef enum logic [2:0] {
    KIND_WORD        = 3'd0,
    KIND_DONE        = 3'd1,
    KIND_ILLEGAL     = 3'd2,
    KIND_TOO_LONG    = 3'd3,
    KIND_EMPTY       = 3'd4,
    KIND_AFTER_ERROR = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    CLS_A       = 3'd0,
    CLS_C       = 3'd1,
    CLS_G       = 3'd2,
    CLS_T       = 3'd3,
    CLS_SKIP    = 3'd4,
    CLS_ILLEGAL = 3'd5
  } cls_e;

  typedef struct packed {
    logic             action;
    logic [ByteW-1:0] char_byte;
  } beat_t;

  typedef struct packed {
    kind_e             kind;
    logic [WordW-1:0]  packed_word;
    logic [ValidW-1:0] bases_valid;
    logic [LenW-1:0]   seq_length;
    logic [ByteW-1:0]  bad_char;
  } res_t;

  // U is folded onto T; CR, LF and NUL are dropped silently.
  function automatic cls_e classify(input logic [ByteW-1:0] b);
    cls_e c;
    case (b)
      8'h41, 8'h61:               c = CLS_A;
      8'h43, 8'h63:               c = CLS_C;
      8'h47, 8'h67:               c = CLS_G;
      8'h54, 8'h74, 8'h55, 8'h75: c = CLS_T;
      8'h0A, 8'h0D, 8'h00:        c = CLS_SKIP;
      default:                    c = CLS_ILLEGAL;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/ntbp_if.sv
// ----------------------------------------------------------------------------
// ntbp_if
// Valid/ready channels of the packer: sequence input, result and config.
// ----------------------------------------------------------------------------
interface ntbp_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [ntbp_pkg::ByteW-1:0] char_byte;

  modport source (output valid, output action, output char_byte, input ready);
  modport sink   (input valid, input action, input char_byte, output ready);
endinterface

interface ntbp_out_if;
  logic                        valid;
  logic                        ready;
  ntbp_pkg::kind_e             kind;
  logic [ntbp_pkg::WordW-1:0]  packed_word;
  logic [ntbp_pkg::ValidW-1:0] bases_valid;
  logic [ntbp_pkg::LenW-1:0]   seq_length;
  logic [ntbp_pkg::ByteW-1:0]  bad_char;

  modport source (output valid, output kind, output packed_word, output bases_valid,
                  output seq_length, output bad_char, input ready);
  modport sink   (input valid, input kind, input packed_word, input bases_valid,
                  input seq_length, input bad_char, output ready);
endinterface

interface ntbp_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [ntbp_pkg::LenW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ntbp_pack_core.sv
// ----------------------------------------------------------------------------
// ntbp_pack_core
// Sequence state and one-beat update: decode, pack, length check, end.
// ----------------------------------------------------------------------------
module ntbp_pack_core #(
  parameter int unsigned BASES_PER_WORD = ntbp_pkg::BasesPerWordDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  ntbp_pkg::beat_t           beat_i,
  input  logic [ntbp_pkg::LenW-1:0] max_len_i,
  output logic                      res_vld_o,
  output ntbp_pkg::res_t            res_o
);

  localparam int unsigned FillW = $clog2(BASES_PER_WORD);
  localparam logic [FillW-1:0] FillLast = FillW'(BASES_PER_WORD - 1);

  logic [ntbp_pkg::WordW-1:0] buf_q, buf_d, buf_or;
  logic [FillW-1:0]           fill_q, fill_d;
  logic [ntbp_pkg::LenW-1:0]  count_q, count_d;
  logic                       err_q, err_d;
  ntbp_pkg::cls_e             cls;

  assign cls    = ntbp_pkg::classify(beat_i.char_byte);
  assign buf_or = buf_q | ({{(ntbp_pkg::WordW-2){1'b0}}, cls[1:0]} << {fill_q, 1'b0});

  always_comb begin
    buf_d     = buf_q;
    fill_d    = fill_q;
    count_d   = count_q;
    err_d     = err_q;
    res_vld_o = 1'b0;
    res_o     = '0;
    if (beat_i.action) begin
      res_vld_o = 1'b1;
      if (err_q) begin
        res_o.kind = ntbp_pkg::KIND_AFTER_ERROR;
      end else if (count_q == '0) begin
        res_o.kind = ntbp_pkg::KIND_EMPTY;
      end else begin
        res_o.kind        = ntbp_pkg::KIND_DONE;
        res_o.packed_word = buf_q;
        res_o.bases_valid = ntbp_pkg::ValidW'(fill_q);
        res_o.seq_length  = count_q;
      end
      buf_d   = '0;
      fill_d  = '0;
      count_d = '0;
      err_d   = 1'b0;
    end else if (!err_q) begin
      case (cls)
        ntbp_pkg::CLS_SKIP: ;
        ntbp_pkg::CLS_ILLEGAL: begin
          err_d          = 1'b1;
          res_vld_o      = 1'b1;
          res_o.kind     = ntbp_pkg::KIND_ILLEGAL;
          res_o.bad_char = beat_i.char_byte;
        end
        default: begin
          if (count_q >= max_len_i) begin
            err_d      = 1'b1;
            res_vld_o  = 1'b1;
            res_o.kind = ntbp_pkg::KIND_TOO_LONG;
          end else begin
            count_d = count_q + 1'b1;
            if (fill_q == FillLast) begin
              res_vld_o         = 1'b1;
              res_o.kind        = ntbp_pkg::KIND_WORD;
              res_o.packed_word = buf_or;
              res_o.bases_valid = ntbp_pkg::ValidW'(BASES_PER_WORD);
              buf_d             = '0;
              fill_d            = '0;
            end else begin
              buf_d  = buf_or;
              fill_d = fill_q + 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q   <= '0;
      fill_q  <= '0;
      count_q <= '0;
      err_q   <= 1'b0;
    end else if (fire_i) begin
      buf_q   <= buf_d;
      fill_q  <= fill_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

endmodule

// File: rtl/nucleotide_two_bit_packer.sv
// ----------------------------------------------------------------------------
// nucleotide_two_bit_packer
// Packs nucleotide bytes into words of 2-bit codes, first base lowest.
// A beat is held in the input register, then goes through the core into the result register.
// Throughput: one beat per cycle unless output stalls, set by the single-pass pack update.
// Reset clears the sequence state and sets max_length to its upper limit.
// ----------------------------------------------------------------------------
module nucleotide_two_bit_packer #(
  parameter int unsigned BASES_PER_WORD = ntbp_pkg::BasesPerWordDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ntbp_in_if.sink       in_i,
  ntbp_cfg_if.sink      cfg_i,
  ntbp_out_if.source    out_o
);

  // Input register: the beat waits here for one pass through the core.
  logic            in_vld_q;
  ntbp_pkg::beat_t in_beat_q;

  // Result register.
  logic            out_vld_q;
  ntbp_pkg::res_t  out_res_q;

  logic                      adv;
  logic                      fire;
  logic                      core_vld;
  ntbp_pkg::res_t            core_res;
  logic [ntbp_pkg::LenW-1:0] max_len_q;

  // The result stage moves whenever it is empty or being drained.
  assign adv        = !out_vld_q || out_o.ready;
  assign fire       = in_vld_q && adv;
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_beat_q.action    <= in_i.action;
      in_beat_q.char_byte <= in_i.char_byte;
    end
  end

  // Config beats always taken; values above the hard limit are clamped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= ntbp_pkg::HardLengthLimit;
    end else if (cfg_i.valid) begin
      max_len_q <= (cfg_i.data > ntbp_pkg::HardLengthLimit) ?
                   ntbp_pkg::HardLengthLimit : cfg_i.data;
    end
  end

  ntbp_pack_core #(
    .BASES_PER_WORD (BASES_PER_WORD)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .beat_i    (in_beat_q),
    .max_len_i (max_len_q),
    .res_vld_o (core_vld),
    .res_o     (core_res)
  );

  // Skipped and dropped bytes leave the result stage empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= fire && core_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.kind        = out_res_q.kind;
  assign out_o.packed_word = out_res_q.packed_word;
  assign out_o.bases_valid = out_res_q.bases_valid;
  assign out_o.seq_length  = out_res_q.seq_length;
  assign out_o.bad_char    = out_res_q.bad_char;

  // A held input beat must not move while the result stage is blocked.
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(in_beat_q))
    else $error("input beat lost or changed while stalled");

  // Full words always carry a whole word of bases.
  a_word_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.kind == ntbp_pkg::KIND_WORD |->
    out_o.bases_valid == ntbp_pkg::ValidW'(BASES_PER_WORD))
    else $error("full word with wrong base count");

  // A completed sequence is never empty and never fills a whole word.
  a_done_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.kind == ntbp_pkg::KIND_DONE |->
    out_o.seq_length != '0 && out_o.bases_valid < ntbp_pkg::ValidW'(BASES_PER_WORD))
    else $error("bad length on sequence done");

endmodule

// File: tb/sv/tb_nucleotide_two_bit_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nucleotide_two_bit_packer
// Drives byte and end-of-sequence beats into the nucleotide packer under
// random stalls on both channels. A scoreboard class predicts every result
// beat from its own copy of the packing state and max_length, and compares
// each accepted result field by field in order.
// ----------------------------------------------------------------------------
module tb_nucleotide_two_bit_packer;
  import ntbp_pkg::*;

  localparam int unsigned BPW           = BasesPerWordDefault;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 6;   // lets the input and result registers empty, plus margin
  localparam int unsigned LONG_HOLD     = 150;
  localparam int unsigned PHASE_BEATS   = 60;
  localparam int unsigned N_PHASES      = 8;

  // action field
  localparam logic ACT_BASE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // bytes that are skipped without a result
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam logic [7:0] BASE_CHARS [10] = '{"A", "a", "C", "c", "G", "g",
                                              "T", "t", "U", "u"};

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the packer state and holds the expected result beats.
  // --------------------------------------------------------------------------
  class packer_scoreboard;
    logic [WordW-1:0] pack_buf;
    int unsigned      fill;
    logic [LenW-1:0]  base_cnt;
    bit               err_flag;
    logic [LenW-1:0]  max_len;
    res_t             expected_q[$];
    int unsigned      mismatches;

    function new();
      clear_sequence();
      max_len    = HardLengthLimit;
      mismatches = 0;
    endfunction

    function void clear_sequence();
      pack_buf = '0;
      fill     = 0;
      base_cnt = '0;
      err_flag = 1'b0;
    endfunction

    // register write, clamped to the hard limit
    function void set_max_length(logic [LenW-1:0] v);
      max_len = (v > HardLengthLimit) ? HardLengthLimit : v;
    endfunction

    function cls_e decode_byte(logic [7:0] b);
      cls_e c;
      case (b)
        "A", "a":           c = CLS_A;
        "C", "c":           c = CLS_C;
        "G", "g":           c = CLS_G;
        "T", "t", "U", "u": c = CLS_T;
        CH_LF, CH_CR, CH_NUL: c = CLS_SKIP;
        default:            c = CLS_ILLEGAL;
      endcase
      return c;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // queue one expected result beat at the tail
    function void expect_beat(res_t r);
      expected_q = {expected_q, r};
    endfunction

    // one accepted input beat
    function void note_beat(logic act, logic [7:0] b);
      res_t r;
      cls_e code;
      r = '0;
      if (act == ACT_END) begin
        if (err_flag) begin
          r.kind = KIND_AFTER_ERROR;
        end else if (base_cnt == 0) begin
          r.kind = KIND_EMPTY;
        end else begin
          r.kind        = KIND_DONE;
          r.packed_word = pack_buf;
          r.bases_valid = ValidW'(fill);
          r.seq_length  = base_cnt;
        end
        expect_beat(r);
        clear_sequence();
        return;
      end
      if (err_flag) return;
      code = decode_byte(b);
      if (code == CLS_SKIP) return;
      if (code == CLS_ILLEGAL) begin
        err_flag   = 1'b1;
        r.kind     = KIND_ILLEGAL;
        r.bad_char = b;
        expect_beat(r);
        return;
      end
      if (base_cnt >= max_len) begin
        err_flag = 1'b1;
        r.kind   = KIND_TOO_LONG;
        expect_beat(r);
        return;
      end
      pack_buf = pack_buf | (WordW'(code) << (2 * fill));
      fill++;
      base_cnt++;
      if (fill >= BPW) begin
        r.kind        = KIND_WORD;
        r.packed_word = pack_buf;
        r.bases_valid = ValidW'(BPW);
        expect_beat(r);
        pack_buf = '0;
        fill     = 0;
      end
    endfunction

    task report_mismatch(string what);
      if (mismatches < 40) $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected, kind %0d", got.kind));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.packed_word !== want.packed_word)
        report_mismatch($sformatf("packed_word %h, want %h", got.packed_word,
                                  want.packed_word));
      if (got.bases_valid !== want.bases_valid)
        report_mismatch($sformatf("bases_valid %0d, want %0d", got.bases_valid,
                                  want.bases_valid));
      if (got.seq_length !== want.seq_length)
        report_mismatch($sformatf("seq_length %0d, want %0d", got.seq_length,
                                  want.seq_length));
      if (got.bad_char !== want.bad_char)
        report_mismatch($sformatf("bad_char %h, want %h", got.bad_char, want.bad_char));
    endtask

    task flush_leftovers();
      res_t want;
      while (expected_q.size() != 0) begin
        want = expected_q.pop_front();
        report_mismatch($sformatf("expected result never came, kind %0d", want.kind));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  ntbp_in_if  in_if();
  ntbp_out_if out_if();
  ntbp_cfg_if cfg_if();

  nucleotide_two_bit_packer #(
    .BASES_PER_WORD (BPW)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  packer_scoreboard sb = new();

  // idling controls shared between the sender and receiver processes
  bit sender_eager   = 1'b0;   // sender offers back to back
  bit receiver_eager = 1'b0;   // receiver never stalls of its own accord
  bit hold_request   = 1'b0;   // ask the receiver for one long hold-off
  int unsigned beats_sent = 0;
  int unsigned cycle_count = 0;
  res_t observed_res;

  // mostly no gap, some short ones and the odd long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // --------------------------------------------------------------------------
  // Input side. send_beat leaves valid high after its handshake; whatever
  // follows in the same step either offers the next beat or drops valid.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic act, input logic [7:0] b);
    int unsigned gap;
    gap = sender_eager ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.action    <= act;
    in_if.char_byte <= b;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_beat(act, b);
    beats_sent++;
  endtask

  task automatic send_base(input logic [7:0] b);
    send_beat(ACT_BASE, b);
  endtask

  // the byte is ignored on an end beat, so it carries noise
  task automatic send_end();
    send_beat(ACT_END, 8'($urandom_range(0, 255)));
  endtask

  // drop valid, wait for every expected beat, then let the pipe empty
  task automatic settle_block();
    int unsigned guard;
    in_if.valid <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_max_length(input logic [LenW-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    sb.set_max_length(v);
  endtask

  function automatic int unsigned pick_seq_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 0;
    if (r < 12) return BPW;          // ends on an exact word boundary
    if (r < 17) return 2 * BPW;
    if (r < 27 && sb.max_len <= 100) return sb.max_len + $urandom_range(0, 2);
    if (r < 30) return $urandom_range(3 * BPW, 4 * BPW + 2);
    return $urandom_range(1, 40);
  endfunction

  // well-formed sequence with random content, sometimes with a bad byte
  task automatic send_sequence();
    int unsigned len;
    int unsigned bad_pct;
    int unsigned r;
    len     = pick_seq_len();
    bad_pct = ($urandom_range(0, 99) < 70) ? 0 : 4;
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < bad_pct)
        send_base(8'($urandom_range(0, 255)));
      else if (r < bad_pct + 5)
        case ($urandom_range(0, 2))
          0:       send_base(CH_LF);
          1:       send_base(CH_CR);
          default: send_base(CH_NUL);
        endcase
      else
        send_base(BASE_CHARS[$urandom_range(0, 9)]);
    end
    send_end();
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 99) < 30) send_end();
    else send_base(8'($urandom_range(0, 255)));
  endtask

  // Hold the receiver off for a long stretch and keep offering beats, most of
  // which cause a result, so the block backs up and stalls its input.
  task automatic squeeze_output();
    hold_request = 1'b1;
    sender_eager = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0) send_base(BASE_CHARS[$urandom_range(0, 9)]);
      if (i % 5 == 1) send_base(8'h7F);
      send_end();
    end
    sender_eager = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Output side: ready with random stalls, long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    int unsigned gap;
    out_if.ready <= 1'b0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        gap = receiver_eager ? 0 : pick_gap();
        if (gap != 0) begin
          out_if.ready <= 1'b0;
          stall_left = gap - 1;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  // result beats are checked at the edge they are taken
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      observed_res.kind        = out_if.kind;
      observed_res.packed_word = out_if.packed_word;
      observed_res.bases_valid = out_if.bases_valid;
      observed_res.seq_length  = out_if.seq_length;
      observed_res.bad_char    = out_if.bad_char;
      sb.check_result(observed_res);
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [LenW-1:0] phase_max [N_PHASES];
    int unsigned     phase_start;
    bit              paused;

    in_if.valid     <= 1'b0;
    in_if.action    <= ACT_BASE;
    in_if.char_byte <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.data     <= '0;

    // settings: hard limit, above it (clamped), zero, one, word-ish, random
    phase_max[0] = HardLengthLimit;
    phase_max[1] = {LenW{1'b1}};
    phase_max[2] = '0;
    phase_max[3] = LenW'(1);
    phase_max[4] = LenW'(BPW + 1);
    phase_max[5] = LenW'(2 * BPW);
    phase_max[6] = LenW'($urandom_range(2, 100));
    phase_max[7] = LenW'($urandom_range(1, 1000));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    // directed: every base letter in both cases, the skipped bytes, then end
    foreach (BASE_CHARS[i]) send_base(BASE_CHARS[i]);
    send_base(CH_CR);
    send_base(CH_LF);
    send_base(CH_NUL);
    send_end();
    // end with no bases
    send_end();
    // illegal byte, a byte dropped after the error, end after error
    send_base("N");
    send_base("A");
    send_end();
    // top of the byte range and the first byte above 127
    send_base(8'hFF);
    send_end();
    send_base(8'h80);
    send_end();
    // one base allowed: the second is too long
    settle_block();
    write_max_length(LenW'(1));
    send_base("C");
    send_base("g");
    send_end();

    // random phases, one register setting each
    for (int p = 0; p < N_PHASES; p++) begin
      settle_block();
      write_max_length(phase_max[p]);
      receiver_eager = (p == 5);
      sender_eager   = (p == 5);
      paused         = 1'b0;
      phase_start    = beats_sent;
      if (p == 4) squeeze_output();
      while (beats_sent - phase_start < PHASE_BEATS) begin
        // halfway through phase 2 the sender waits once for every result before carrying on
        if (p == 2 && !paused && beats_sent - phase_start >= PHASE_BEATS / 2) begin
          settle_block();
          paused = 1'b1;
        end
        if ($urandom_range(0, 99) < 80) send_sequence();
        else send_noise();
      end
      receiver_eager = 1'b0;
      sender_eager   = 1'b0;
    end

    settle_block();
    sb.flush_leftovers();
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ntbp_pkg.sv
rtl/ntbp_if.sv
rtl/ntbp_pack_core.sv
rtl/nucleotide_two_bit_packer.sv
tb/sv/tb_nucleotide_two_bit_packer.sv
